// ===== hdl/ensc_pkg.sv =====
// Shared types, constants and month table for the epoch-to-calendar converter.
package ensc_pkg;

    localparam logic signed [63:0] NsNegLimit = -64'sd1000000000;
    localparam logic [29:0] NsPerSec   = 30'd1000000000;
    localparam logic [29:0] SecPerDay  = 30'd86400;
    localparam logic [29:0] SecPerHour = 30'd3600;
    localparam logic [29:0] SecPerMin  = 30'd60;
    localparam logic [13:0] EpochYear  = 14'd1970;
    localparam logic [13:0] YearLimit  = 14'd9999;
    localparam logic [6:0]  EpochMod100 = 7'd70;
    localparam logic [8:0]  EpochMod400 = 9'd370;
    localparam int          DivSteps   = 8;
    localparam int          StepW      = $clog2(DivSteps);

    // floor(2^64 / d); no divisor is a power of two, so the all-ones numerator matches
    localparam logic [63:0] RecipSec  = 64'hFFFF_FFFF_FFFF_FFFF / 64'(NsPerSec);
    localparam logic [63:0] RecipDay  = 64'hFFFF_FFFF_FFFF_FFFF / 64'(SecPerDay);
    localparam logic [63:0] RecipHour = 64'hFFFF_FFFF_FFFF_FFFF / 64'(SecPerHour);
    localparam logic [63:0] RecipMin  = 64'hFFFF_FFFF_FFFF_FFFF / 64'(SecPerMin);

    // divide pass in progress; also picks the divisor
    typedef enum logic [1:0] {
        PH_SEC,
        PH_DAY,
        PH_HOUR,
        PH_MIN
    } phase_t;

    // micro-steps of one divide pass, in order
    typedef enum logic [2:0] {
        OP_LO_LO,
        OP_HI_LO,
        OP_LO_HI,
        OP_HI_HI,
        OP_QLO,
        OP_QHI,
        OP_REM,
        OP_FIX
    } div_op_t;

    typedef struct packed {
        logic    accept;
        logic    div_step;
        logic    load;
        logic    year_step;
        logic    month_step;
        logic    fail;
        logic    publish;
        phase_t  phase;
        div_op_t div_op;
    } ensc_cmd_t;

    typedef struct packed {
        logic bad_input;
        logic year_fits;
        logic year_last;
        logic month_fits;
    } ensc_stat_t;

    typedef struct packed {
        logic        valid_res;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } ensc_res_t;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:    len = 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/ensc_in_if.sv =====
// Input channel: one nanosecond timestamp per beat.
interface ensc_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] nanoseconds;

    modport source (output valid, output nanoseconds, input ready);
    modport sink   (input valid, input nanoseconds, output ready);
endinterface

// ===== hdl/ensc_out_if.sv =====
// Output channel: one calendar date and time per beat.
interface ensc_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    modport source (output valid, output valid_res, output year, output month, output day,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input valid_res, input year, input month, input day,
                    input hour, input minute, input second, output ready);
endinterface

// ===== hdl/ensc_dp.sv =====
// Datapath: shared reciprocal divider, year/month walk and result register.
module ensc_dp (
    input  logic                  clk,
    input  logic [63:0]           nanoseconds,
    input  ensc_pkg::ensc_cmd_t   cmd,
    output ensc_pkg::ensc_stat_t  stat,
    output ensc_pkg::ensc_res_t   res
);

    logic [63:0] dvd_reg, dvd_next;
    logic [29:0] rem_reg, rem_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] aux_reg, aux_next;
    logic [63:0] quo_reg, quo_next;
    logic        ok_reg, ok_next;
    logic [16:0] day_reg, day_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  ymod100_reg, ymod100_next;
    logic [8:0]  ymod400_reg, ymod400_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  hour_reg, hour_next;
    ensc_pkg::ensc_res_t res_reg, res_next;

    logic signed [63:0] ns_s;
    logic        bad;
    logic [29:0] divisor;
    logic [63:0] recip;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] sum_hl, sum_lh;
    logic        fix_ge;
    logic [30:0] rem_fix;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    assign ns_s = nanoseconds;
    assign bad  = nanoseconds[63] && (ns_s <= ensc_pkg::NsNegLimit);

    always_comb
    begin
        case (cmd.phase)
            ensc_pkg::PH_SEC:
            begin
                divisor = ensc_pkg::NsPerSec;
                recip   = ensc_pkg::RecipSec;
            end
            ensc_pkg::PH_DAY:
            begin
                divisor = ensc_pkg::SecPerDay;
                recip   = ensc_pkg::RecipDay;
            end
            ensc_pkg::PH_HOUR:
            begin
                divisor = ensc_pkg::SecPerHour;
                recip   = ensc_pkg::RecipHour;
            end
            default:
            begin
                divisor = ensc_pkg::SecPerMin;
                recip   = ensc_pkg::RecipMin;
            end
        endcase
    end

    // one 32x32 product per step: dividend times reciprocal, then quotient times divisor
    always_comb
    begin
        case (cmd.div_op)
            ensc_pkg::OP_LO_LO:
            begin
                mul_a = dvd_reg[31:0];
                mul_b = recip[31:0];
            end
            ensc_pkg::OP_HI_LO:
            begin
                mul_a = dvd_reg[63:32];
                mul_b = recip[31:0];
            end
            ensc_pkg::OP_LO_HI:
            begin
                mul_a = dvd_reg[31:0];
                mul_b = recip[63:32];
            end
            ensc_pkg::OP_HI_HI:
            begin
                mul_a = dvd_reg[63:32];
                mul_b = recip[63:32];
            end
            ensc_pkg::OP_QLO:
            begin
                mul_a = quo_reg[31:0];
                mul_b = {2'b00, divisor};
            end
            ensc_pkg::OP_QHI:
            begin
                mul_a = quo_reg[63:32];
                mul_b = {2'b00, divisor};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = {32'd0, mul_a} * {32'd0, mul_b};
    assign sum_hl  = prod + acc_reg;
    assign sum_lh  = prod + {32'd0, aux_reg};
    assign fix_ge  = acc_reg >= {34'd0, divisor};
    assign rem_fix = acc_reg[30:0] - {1'b0, divisor};

    assign leap = ((year_reg[1:0] == 2'd0) && (ymod100_reg != 7'd0)) || (ymod400_reg == 9'd0);
    assign ylen = leap ? 9'd366 : 9'd365;

    always_comb
    begin
        mlen = ensc_pkg::month_len(month_reg);
        if (month_reg == 4'd2 && leap)
        begin
            mlen = 5'd29;
        end
    end

    always_comb
    begin
        stat.bad_input  = bad;
        stat.year_fits  = day_reg <= {8'd0, ylen};
        stat.year_last  = year_reg == ensc_pkg::YearLimit;
        stat.month_fits = day_reg <= {12'd0, mlen};
    end

    always_comb
    begin
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        acc_next     = acc_reg;
        aux_next     = aux_reg;
        quo_next     = quo_reg;
        ok_next      = ok_reg;
        day_next     = day_reg;
        year_next    = year_reg;
        ymod100_next = ymod100_reg;
        ymod400_next = ymod400_reg;
        month_next   = month_reg;
        hour_next    = hour_reg;
        res_next     = res_reg;

        if (cmd.accept)
        begin
            // small negative counts truncate to zero seconds
            dvd_next = nanoseconds[63] ? 64'd0 : nanoseconds;
            rem_next = '0;
            ok_next  = !bad;
        end

        if (cmd.div_step)
        begin
            case (cmd.div_op)
                ensc_pkg::OP_LO_LO: acc_next = {32'd0, prod[63:32]};
                ensc_pkg::OP_HI_LO:
                begin
                    acc_next = {32'd0, sum_hl[63:32]};
                    aux_next = sum_hl[31:0];
                end
                ensc_pkg::OP_LO_HI: acc_next = acc_reg + {32'd0, sum_lh[63:32]};
                ensc_pkg::OP_HI_HI: quo_next = prod + acc_reg;
                ensc_pkg::OP_QLO:   acc_next = prod;
                ensc_pkg::OP_QHI:   acc_next = acc_reg + {prod[31:0], 32'd0};
                ensc_pkg::OP_REM:   acc_next = dvd_reg - acc_reg;
                default:
                begin
                    // estimate is low by at most one
                    dvd_next = fix_ge ? quo_reg + 64'd1 : quo_reg;
                    rem_next = fix_ge ? rem_fix[29:0] : acc_reg[29:0];
                end
            endcase
        end

        if (cmd.load)
        begin
            case (cmd.phase)
                ensc_pkg::PH_DAY:
                begin
                    rem_next = '0;
                end
                ensc_pkg::PH_HOUR:
                begin
                    day_next     = dvd_reg[16:0] + 17'd1;
                    year_next    = ensc_pkg::EpochYear;
                    ymod100_next = ensc_pkg::EpochMod100;
                    ymod400_next = ensc_pkg::EpochMod400;
                    month_next   = 4'd1;
                    dvd_next     = {34'd0, rem_reg};
                    rem_next     = '0;
                end
                ensc_pkg::PH_MIN:
                begin
                    hour_next = dvd_reg[4:0];
                    dvd_next  = {34'd0, rem_reg};
                    rem_next  = '0;
                end
                default:
                begin
                    rem_next = '0;
                end
            endcase
        end

        if (cmd.year_step)
        begin
            day_next     = day_reg - {8'd0, ylen};
            year_next    = year_reg + 14'd1;
            ymod100_next = (ymod100_reg == 7'd99) ? 7'd0 : ymod100_reg + 7'd1;
            ymod400_next = (ymod400_reg == 9'd399) ? 9'd0 : ymod400_reg + 9'd1;
        end

        if (cmd.month_step)
        begin
            day_next   = day_reg - {12'd0, mlen};
            month_next = month_reg + 4'd1;
        end

        if (cmd.fail)
        begin
            ok_next = 1'b0;
        end

        if (cmd.publish)
        begin
            res_next = '0;
            if (ok_reg)
            begin
                res_next.valid_res = 1'b1;
                res_next.year      = year_reg[11:0];
                res_next.month     = month_reg;
                res_next.day       = day_reg[4:0];
                res_next.hour      = hour_reg;
                res_next.minute    = dvd_reg[5:0];
                res_next.second    = rem_reg[5:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        acc_reg     <= acc_next;
        aux_reg     <= aux_next;
        quo_reg     <= quo_next;
        ok_reg      <= ok_next;
        day_reg     <= day_next;
        year_reg    <= year_next;
        ymod100_reg <= ymod100_next;
        ymod400_reg <= ymod400_next;
        month_reg   <= month_next;
        hour_reg    <= hour_next;
        res_reg     <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== hdl/ensc_ctrl.sv =====
// Controller: sequences the divide passes, the calendar walk and the output beat.
module ensc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ensc_pkg::ensc_stat_t stat,
    output ensc_pkg::ensc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_LOAD,
        S_YEAR,
        S_MONTH,
        S_FIN
    } state_t;

    state_t                     state_reg, state_next;
    ensc_pkg::phase_t           phase_reg, phase_next;
    logic [ensc_pkg::StepW-1:0] step_reg, step_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       last_step;

    assign last_step = step_reg == ensc_pkg::StepW'(ensc_pkg::DivSteps - 1);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.phase      = phase_reg;
        cmd.div_op     = ensc_pkg::div_op_t'(step_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    phase_next = ensc_pkg::PH_SEC;
                    step_next  = '0;
                    state_next = stat.bad_input ? S_FIN : S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (last_step)
                begin
                    state_next = S_LOAD;
                    case (phase_reg)
                        ensc_pkg::PH_SEC:  phase_next = ensc_pkg::PH_DAY;
                        ensc_pkg::PH_DAY:  phase_next = ensc_pkg::PH_HOUR;
                        ensc_pkg::PH_HOUR: phase_next = ensc_pkg::PH_MIN;
                        default:           state_next = S_YEAR;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_YEAR:
            begin
                if (stat.year_fits)
                begin
                    state_next = S_MONTH;
                end
                else if (stat.year_last)
                begin
                    cmd.fail   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.year_step = 1'b1;
                end
            end
            S_MONTH:
            begin
                if (stat.month_fits)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.month_step = 1'b1;
                end
            end
            S_FIN:
            begin
                // result register free or draining this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= ensc_pkg::PH_SEC;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/epoch_ns_to_calendar_date_unit.sv =====
// Top level: epoch nanoseconds to Gregorian UTC date and time, one item at a time.
// Steps: 4 divide passes of 8 steps (reciprocal multiply on one 32x32 multiplier, then a
// remainder fix) with a reload between passes, then the year walk (Y <= 292 years skipped)
// and the month walk, then the load of the result register; a bad input goes straight to
// that load, and a full result register stalls the load. An item is taken only in idle,
// after the last one is published; the result register lets the next item start.
// Reset (rst_n, async low) idles the controller and marks the result register empty (dout.valid low).
module epoch_ns_to_calendar_date_unit (
    input  logic              clk,
    input  logic              rst_n,
    ensc_in_if.sink           din,
    ensc_out_if.source        dout
);

    ensc_pkg::ensc_cmd_t  cmd;
    ensc_pkg::ensc_stat_t stat;
    ensc_pkg::ensc_res_t  res;

    ensc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_ready  (din.ready),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ensc_dp u_dp (
        .clk         (clk),
        .nanoseconds (din.nanoseconds),
        .cmd         (cmd),
        .stat        (stat),
        .res         (res)
    );

    assign dout.valid_res = res.valid_res;
    assign dout.year      = res.year;
    assign dout.month     = res.month;
    assign dout.day       = res.day;
    assign dout.hour      = res.hour;
    assign dout.minute    = res.minute;
    assign dout.second    = res.second;

endmodule

// ===== hdl/ensc_checker.sv =====
// Port-level checks for the converter, bound to the top level.
module ensc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        valid_res,
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second
);

    // one item in flight: no second beat right after a taken one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while previous item still in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before taken");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> year == 12'd0 && month == 4'd0 && day == 5'd0
            && hour == 5'd0 && minute == 6'd0 && second == 6'd0)
        else $error("invalid result carries nonzero fields");

    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> year >= 12'd1970 && month >= 4'd1 && month <= 4'd12
            && day >= 5'd1 && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
        else $error("valid result out of calendar range");

endmodule

bind epoch_ns_to_calendar_date_unit ensc_checker u_ensc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .valid_res (dout.valid_res),
    .year      (dout.year),
    .month     (dout.month),
    .day       (dout.day),
    .hour      (dout.hour),
    .minute    (dout.minute),
    .second    (dout.second)
);
